// ----- design/drla_pkg.sv -----
// ----------------------------------------------------------------------------
// drla_pkg: shared types and constants of the detent rate-limited actuator
// Q16.16 position and time types, configuration register map and reset
// values, and the bundle of configuration registers passed to the core.
// ----------------------------------------------------------------------------
package drla_pkg;

    localparam int POS_W        = 32;
    localparam int DUR_W        = 32;
    localparam int DETENT_SLOTS = 4;
    localparam int SEG_SLOTS    = DETENT_SLOTS - 1;
    localparam int SEG_W        = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = 5;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic        [DUR_W-1:0] dur_t;
    typedef logic        [SEG_W-1:0] seg_t;

    typedef struct packed {
        pos_t [DETENT_SLOTS-1:0] detent;
        dur_t [SEG_SLOTS:1]      seg_time;
        logic                    scale_en;
    } cfg_t;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_TIME_1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_TIME_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_TIME_3 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EN  = 3'd7;

    // Reset values: detents at 0, 1.0, 2.0, 3.0; every segment 1.0 s
    localparam pos_t DETENT_0_RST = 32'sh0000_0000;
    localparam pos_t DETENT_1_RST = 32'sh0001_0000;
    localparam pos_t DETENT_2_RST = 32'sh0002_0000;
    localparam pos_t DETENT_3_RST = 32'sh0003_0000;
    localparam dur_t SEG_TIME_RST = 32'h0001_0000;

    localparam pos_t POS_MAX = 32'sh7FFF_FFFF;
    localparam pos_t POS_MIN = 32'sh8000_0000;

endpackage

// ----- design/drla_div.sv -----
// ----------------------------------------------------------------------------
// drla_div: iterative restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// The upper dividend half must be below the divisor, so the quotient fits.
// ----------------------------------------------------------------------------
module drla_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quot,
    output logic [31:0] rem
);
    import drla_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          dq_reg, dq_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic [32:0]          trial;
    logic [32:0]          diff;
    logic                 ge;

    assign trial = {rem_reg, dq_reg[31]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[63:32];
            dq_next   = dividend[31:0];
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[31:0] : trial[31:0];
            dq_next  = {dq_reg[30:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = dq_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/drla_core.sv -----
// ----------------------------------------------------------------------------
// drla_core: sequencer and datapath of the actuator
// Scales (if enabled) and clamps the command, then, unless in trim mode, walks
// the segments one pass at a time on a shared multiplier and the iterative divider.
// ----------------------------------------------------------------------------
module drla_core #(
    parameter int NUM_DETENTS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  drla_pkg::cfg_t cfg,
    input  logic           start,
    input  drla_pkg::pos_t cmd_in,
    input  drla_pkg::dur_t budget_in,
    input  logic           trim_in,
    output logic           idle,
    output logic           res_valid,
    input  logic           res_ready,
    output drla_pkg::pos_t res_pos,
    output logic           res_reached
);
    import drla_pkg::*;

    localparam int LAST     = NUM_DETENTS - 1;
    localparam int PASS_MAX = 2 * NUM_DETENTS;
    localparam int PASS_W   = $clog2(PASS_MAX + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SMUL  = 4'd1;
    localparam logic [3:0] S_CLAMP = 4'd2;
    localparam logic [3:0] S_PASS  = 4'd3;
    localparam logic [3:0] S_SEG   = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]        state_reg, state_next;
    pos_t              pos_reg, pos_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    pos_t              cmd_reg, cmd_next;
    dur_t              budget_reg, budget_next;
    logic              trim_reg, trim_next;
    pos_t              target_reg, target_next;
    seg_t              k_reg, k_next;
    dur_t              t_reg, t_next;
    logic [31:0]       span_reg, span_next;
    pos_t              segtgt_reg, segtgt_next;
    logic [31:0]       dist_reg, dist_next;
    logic              up_reg, up_next;
    logic [63:0]       prod_reg, prod_next;
    logic [63:0]       x_reg, x_next;
    logic              short_reg, short_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    pos_t        first_det, last_det, scaled, cmd_eff, clamped;
    seg_t        k_sel;
    pos_t        lo, hi, seg_clamp;
    logic [32:0] span_d, dist_d;
    logic        short_cmp;
    logic        div_start, div_done;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor, div_q, div_r;
    logic [32:0] moved, need;

    // Shared multiplier, product registered before use
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SMUL:
            begin
                mul_a = {cmd_reg[31], cmd_reg};
                mul_b = {last_det[31], last_det};
            end
            S_MUL1:
            begin
                mul_a = {1'b0, dist_reg};
                mul_b = {1'b0, t_reg};
            end
            S_MUL2:
            begin
                mul_a = {1'b0, budget_reg};
                mul_b = {1'b0, span_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_next = mul_p[63:0];

    assign first_det = cfg.detent[0];
    assign last_det  = cfg.detent[LAST];

    // Floor shift by 16, saturate to 32 bits
    always_comb
    begin
        if ((&prod_reg[63:47]) || !(|prod_reg[63:47]))
            scaled = prod_reg[47:16];
        else
            scaled = prod_reg[63] ? POS_MIN : POS_MAX;
        cmd_eff = cfg.scale_en ? scaled : cmd_reg;
        priority if (cmd_eff < first_det)
            clamped = first_det;
        else if (cmd_eff > last_det)
            clamped = last_det;
        else
            clamped = cmd_eff;
    end

    // Segment search: stop at the first upper detent past the position
    always_comb
    begin
        logic searching;
        logic down;
        pos_t dj;
        searching = 1'b1;
        down      = target_reg < pos_reg;
        k_sel     = SEG_W'(1);
        for (int j = 1; j < NUM_DETENTS - 1; j++)
        begin
            dj = cfg.detent[j];
            if (searching && (down ? (dj < pos_reg) : (dj <= pos_reg)))
                k_sel = SEG_W'(j + 1);
            else
                searching = 1'b0;
        end
    end

    // Segment geometry
    always_comb
    begin
        lo     = cfg.detent[k_reg - 1'b1];
        hi     = cfg.detent[k_reg];
        span_d = {hi[31], hi} - {lo[31], lo};
        if (span_d[32])
            span_d = -span_d;
        priority if (target_reg < lo)
            seg_clamp = lo;
        else if (target_reg > hi)
            seg_clamp = hi;
        else
            seg_clamp = target_reg;
        dist_d = {seg_clamp[31], seg_clamp} - {pos_reg[31], pos_reg};
        if (dist_d[32])
            dist_d = -dist_d;
    end

    // budget * span below dist * time means the budget runs out in this segment
    assign short_cmp    = prod_reg < x_reg;
    assign div_start    = (state_reg == S_CMP);
    assign div_dividend = short_cmp ? prod_reg : x_reg;
    assign div_divisor  = short_cmp ? t_reg : span_reg;

    assign moved = up_reg ? ({pos_reg[31], pos_reg} + {1'b0, div_q})
                          : ({pos_reg[31], pos_reg} - {1'b0, div_q});
    assign need  = {1'b0, div_q} + {32'd0, (div_r != 32'd0)};

    drla_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        pass_next   = pass_reg;
        cmd_next    = cmd_reg;
        budget_next = budget_reg;
        trim_next   = trim_reg;
        target_next = target_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        span_next   = span_reg;
        segtgt_next = segtgt_reg;
        dist_next   = dist_reg;
        up_next     = up_reg;
        x_next      = x_reg;
        short_next  = short_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd_in;
                    budget_next = budget_in;
                    trim_next   = trim_in;
                    pass_next   = '0;
                    state_next  = cfg.scale_en ? S_SMUL : S_CLAMP;
                end
            end
            S_SMUL:
                state_next = S_CLAMP;
            S_CLAMP:
            begin
                target_next = clamped;
                if (trim_reg)
                begin
                    pos_next   = clamped;
                    state_next = S_DONE;
                end
                else
                    state_next = S_PASS;
            end
            S_PASS:
            begin
                priority if (budget_reg == '0 || pos_reg == target_reg ||
                             pass_reg == PASS_W'(PASS_MAX))
                    state_next = S_DONE;
                else if (cfg.seg_time[k_sel] == '0)
                begin
                    pos_next   = target_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_sel;
                    t_next     = cfg.seg_time[k_sel];
                    pass_next  = pass_reg + 1'b1;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                span_next   = span_d[31:0];
                segtgt_next = seg_clamp;
                dist_next   = dist_d[31:0];
                up_next     = seg_clamp >= pos_reg;
                state_next  = (span_d[31:0] == 32'd0) ? S_DONE : S_MUL1;
            end
            S_MUL1:
                state_next = S_MUL2;
            S_MUL2:
            begin
                x_next     = prod_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                short_next = short_cmp;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (short_reg)
                    begin
                        pos_next    = moved[31:0];
                        budget_next = '0;
                    end
                    else
                    begin
                        pos_next    = segtgt_reg;
                        budget_next = budget_reg - need[31:0];
                    end
                    state_next = S_PASS;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        budget_reg <= budget_next;
        trim_reg   <= trim_next;
        target_reg <= target_next;
        k_reg      <= k_next;
        t_reg      <= t_next;
        span_reg   <= span_next;
        segtgt_reg <= segtgt_next;
        dist_reg   <= dist_next;
        up_reg     <= up_next;
        prod_reg   <= prod_next;
        x_reg      <= x_next;
        short_reg  <= short_next;
    end

    assign idle        = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res_pos     = pos_reg;
    assign res_reached = (pos_reg == target_reg);

endmodule

// ----- design/detent_rate_limited_actuator.sv -----
// ----------------------------------------------------------------------------
// detent_rate_limited_actuator: piecewise rate-limited actuator position
// Moves a stored Q16.16 position toward each commanded position, limited by
// per-segment traverse times between four configurable detents.
// ----------------------------------------------------------------------------
// One item is one tick: a command, a time budget and a trim flag in, the new
// position and a target-reached flag out. The block takes one item at a time
// and drops s_tready until that item's result is loaded into the output
// register; the output register lets the next item enter while the result
// waits on m_tready. A trim item is scaled (if enabled), clamped and loaded
// as the new position. A timed item is scaled and clamped likewise, then
// makes at most 2 * NUM_DETENTS segment passes; each pass picks a segment,
// forms its geometry, multiplies twice, compares, and runs the 32-step
// restoring divider, which with one shared 33x33 multiplier does all rate
// arithmetic. The position persists across items and resets to zero; write
// the detents and segment times only while the block is idle.
// ----------------------------------------------------------------------------
module detent_rate_limited_actuator #(
    parameter int NUM_DETENTS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [63:0]                          s_tdata,  // command_position, step_time
    input  logic                                 s_tuser,  // trim_mode
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata,  // actuator_position
    output logic                                 m_tuser,  // target_reached
    // Configuration writes
    input  logic                                 cfg_we,
    input  logic [drla_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drla_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import drla_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic core_idle;
    logic core_start;
    logic res_valid, res_ready, res_reached;
    pos_t res_pos;

    logic out_valid_reg, out_valid_next;
    pos_t out_pos_reg, out_pos_next;
    logic out_reached_reg, out_reached_next;

    // Register writes: latch the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DETENT_0:   cfg_next.detent[0]   = cfg_data;
                CFG_DETENT_1:   cfg_next.detent[1]   = cfg_data;
                CFG_DETENT_2:   cfg_next.detent[2]   = cfg_data;
                CFG_DETENT_3:   cfg_next.detent[3]   = cfg_data;
                CFG_SEG_TIME_1: cfg_next.seg_time[1] = cfg_data;
                CFG_SEG_TIME_2: cfg_next.seg_time[2] = cfg_data;
                CFG_SEG_TIME_3: cfg_next.seg_time[3] = cfg_data;
                CFG_SCALE_EN:   cfg_next.scale_en    = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detent[0]   <= DETENT_0_RST;
            cfg_reg.detent[1]   <= DETENT_1_RST;
            cfg_reg.detent[2]   <= DETENT_2_RST;
            cfg_reg.detent[3]   <= DETENT_3_RST;
            cfg_reg.seg_time[1] <= SEG_TIME_RST;
            cfg_reg.seg_time[2] <= SEG_TIME_RST;
            cfg_reg.seg_time[3] <= SEG_TIME_RST;
            cfg_reg.scale_en    <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Accept a new item only while the core is idle
    assign s_tready   = core_idle;
    assign core_start = s_tvalid && core_idle;

    drla_core #(
        .NUM_DETENTS (NUM_DETENTS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .start       (core_start),
        .cmd_in      (s_tdata[31:0]),
        .budget_in   (s_tdata[63:32]),
        .trim_in     (s_tuser),
        .idle        (core_idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_pos     (res_pos),
        .res_reached (res_reached)
    );

    // Output register: load when empty or being drained, hold otherwise
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_pos_next     = out_pos_reg;
        out_reached_next = out_reached_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next   = 1'b1;
            out_pos_next     = res_pos;
            out_reached_next = res_reached;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_pos_reg     <= out_pos_next;
        out_reached_reg <= out_reached_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pos_reg;
    assign m_tuser  = out_reached_reg;

endmodule

// ----- design/drla_checker.sv -----
// ----------------------------------------------------------------------------
// drla_checker: port-level checks of the actuator
// Watches the stream handshakes for one-at-a-time item flow and a stable
// result under stall.
// ----------------------------------------------------------------------------
module drla_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // Drop ready after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready stayed high after an accepted item");

    // No result appears the cycle right after an item enters
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared too early after an accepted item");

    // A new result comes with the core back to idle
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded while the core is still busy");

    // Hold a stalled result
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed or vanished");

endmodule

bind detent_rate_limited_actuator drla_checker u_drla_checker (.*);
